// ===== rtl/yaz0_pkg.sv =====
// shared constants for the yaz0 stream decompressor
package yaz0_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int GROUP_BYTES  = 8;
  localparam int OUT_W        = 8 * GROUP_BYTES;
  localparam int CNT_W        = $clog2(GROUP_BYTES) + 1;
  localparam int FILL_W       = $clog2(GROUP_BYTES);
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int DIST_W       = HIST_AW + 1;
  localparam int LEN_W        = 9;

  localparam logic [7:0]       LIT_FLAG_MASK   = 8'h80;
  localparam logic [3:0]       DIST_HI_MASK    = 4'hF;
  localparam logic [LEN_W-1:0] EXT_LEN_BASE    = 9'h012;
  localparam logic [LEN_W-1:0] SHORT_LEN_BASE  = 9'h002;
  localparam logic [3:0]       FLAGS_PER_GROUP = 4'h8;

  localparam logic [CFG_IDX_W-1:0] REG_EXPANDED_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_LIMIT    = 2'd2;

  localparam logic [CFG_W-1:0] EMIT_LIMIT_RESET = 32'hFFFF_FFFF;

endpackage

// ===== rtl/yaz0_stream_decompressor_unit.sv =====
// yaz0 payload decompressor with a 4096-byte history ram and packed output
//
// Takes the payload bytes of a yaz0 stream (after the 16-byte header), one item
// per byte, and returns the decompressed bytes packed eight to a result item.
// A flag byte, a reference byte or a literal byte is taken whenever the block is
// idle; a literal waits only when the output register is still full. A back
// reference copies each byte in two states: S_RD reads the history ram into a
// register, then S_WR writes the byte back and packs it, waiting while the
// output side stalls. The input is not taken while a copy runs. The
// history needs no clearing after reset: a reference reaching before the start
// of the stream reads zero, so only entries written in the current stream are
// ever read. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
module yaz0_stream_decompressor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [yaz0_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [yaz0_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_of_stream,
  input  logic [7:0]                          in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [yaz0_pkg::OUT_W-1:0]          out_bytes,
  output logic [3:0]                          byte_count,
  output logic                                last_of_run,
  output logic                                stream_done
);

  typedef enum logic [1:0] {S_IDLE, S_LIT, S_RD, S_WR} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_LOW, PH_EXT} phase_t;

  state_t state;
  phase_t phase;

  logic [31:0] expanded_size;
  logic [31:0] skip_count;
  logic [31:0] emit_limit;

  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [7:0]  ref_high_byte;
  logic [7:0]  ref_low_byte;
  logic [31:0] logical_position;
  logic [31:0] emitted_total;
  logic        finished;
  logic [7:0]  lit_byte;
  logic [yaz0_pkg::DIST_W-1:0] ref_dist;
  logic [yaz0_pkg::LEN_W-1:0]  copy_left;
  logic        src_zero;

  logic [yaz0_pkg::OUT_W-1:0]  pack_word;
  logic [yaz0_pkg::FILL_W-1:0] pack_fill;

  // history ram
  logic [7:0] hist [yaz0_pkg::WINDOW_DEPTH];
  logic [7:0] hist_rdata;
  logic       hist_we;
  logic       hist_re;
  logic [yaz0_pkg::HIST_AW-1:0] hist_raddr;

  // start of stream clears positions before the byte is looked at
  logic [31:0] pos_eff;
  logic [31:0] emt_eff;
  logic        stop_now;
  logic        accept;
  logic        out_free;

  // shared byte-production datapath
  logic [7:0]  p_byte;
  logic [31:0] p_pos;
  logic [31:0] p_emt;
  logic        p_more;
  logic        p_emit;
  logic [31:0] p_pos_next;
  logic [31:0] p_emt_next;
  logic        p_fin_next;
  logic [yaz0_pkg::OUT_W-1:0] p_word_next;
  logic [yaz0_pkg::CNT_W-1:0] p_cnt;
  logic        p_is_last;
  logic        p_push;
  logic        do_produce;

  logic [7:0]  flag_bits_next;
  logic [3:0]  flags_left_next;
  phase_t      phase_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign pos_eff  = start_of_stream ? 32'd0 : logical_position;
  assign emt_eff  = start_of_stream ? 32'd0 : emitted_total;
  assign stop_now = (!start_of_stream && finished) || (pos_eff >= expanded_size) ||
                    (emt_eff >= emit_limit);

  assign flag_bits_next  = {flag_bits[6:0], 1'b0};
  assign flags_left_next = flags_left - 4'd1;
  assign phase_next      = (flags_left_next == 4'd0) ? PH_FLAG : PH_ITEM;

  assign hist_raddr = logical_position[yaz0_pkg::HIST_AW-1:0] -
                      ref_dist[yaz0_pkg::HIST_AW-1:0];
  assign hist_re    = (state == S_RD);

  always_comb begin
    p_byte = hist_rdata;
    p_pos  = logical_position;
    p_emt  = emitted_total;
    p_more = 1'b0;
    do_produce = 1'b0;
    case (state)
      S_IDLE: begin
        p_byte = in_byte;
        p_pos  = pos_eff;
        p_emt  = emt_eff;
        do_produce = accept && !stop_now && (phase == PH_ITEM || start_of_stream) &&
                     !start_of_stream && ((flag_bits & yaz0_pkg::LIT_FLAG_MASK) != 8'd0) &&
                     out_free;
      end
      S_LIT: begin
        p_byte = lit_byte;
        do_produce = out_free;
      end
      S_WR: begin
        p_byte = src_zero ? 8'd0 : hist_rdata;
        p_more = (copy_left != 9'd1);
        do_produce = out_free;
      end
      default: begin
        do_produce = 1'b0;
      end
    endcase
  end

  always_comb begin
    p_emit      = (p_pos >= skip_count) && (p_emt < emit_limit);
    p_emt_next  = p_emt + {31'd0, p_emit};
    p_pos_next  = p_pos + 32'd1;
    p_fin_next  = (p_pos_next >= expanded_size) || (p_emt_next >= emit_limit);
    p_word_next = pack_word;
    if (p_emit) begin
      p_word_next[{pack_fill, 3'b000} +: 8] = p_byte;
    end
    p_cnt     = {1'b0, pack_fill} + {{(yaz0_pkg::CNT_W-1){1'b0}}, p_emit};
    p_is_last = !p_more || p_fin_next;
    p_push    = p_emit && ((p_cnt == yaz0_pkg::CNT_W'(yaz0_pkg::GROUP_BYTES)) || p_is_last);
  end

  assign hist_we = do_produce;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[p_pos[yaz0_pkg::HIST_AW-1:0]] <= p_byte;
    end
    if (hist_re) begin
      hist_rdata <= hist[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expanded_size <= '0;
      skip_count    <= '0;
      emit_limit    <= yaz0_pkg::EMIT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        yaz0_pkg::REG_EXPANDED_SIZE: expanded_size <= cfg_data;
        yaz0_pkg::REG_SKIP_COUNT:    skip_count    <= cfg_data;
        yaz0_pkg::REG_EMIT_LIMIT:    emit_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_FLAG;
      flag_bits        <= '0;
      flags_left       <= '0;
      ref_high_byte    <= '0;
      ref_low_byte     <= '0;
      logical_position <= '0;
      emitted_total    <= '0;
      finished         <= 1'b0;
      pack_word        <= '0;
      pack_fill        <= '0;
      copy_left        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (do_produce && p_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (do_produce) begin
        logical_position <= p_pos_next;
        emitted_total    <= p_emt_next;
        finished         <= p_fin_next;
        if (p_push) begin
          out_bytes   <= p_word_next;
          byte_count  <= p_cnt;
          last_of_run <= p_is_last;
          stream_done <= p_is_last && p_fin_next;
          pack_word   <= '0;
          pack_fill   <= '0;
        end else begin
          pack_word <= p_word_next;
          pack_fill <= p_cnt[yaz0_pkg::FILL_W-1:0];
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_of_stream) begin
              ref_high_byte    <= '0;
              ref_low_byte     <= '0;
              logical_position <= '0;
              emitted_total    <= '0;
            end
            if (stop_now) begin
              finished <= 1'b1;
              if (start_of_stream) begin
                phase      <= PH_FLAG;
                flag_bits  <= '0;
                flags_left <= '0;
              end
            end else if (start_of_stream || phase == PH_FLAG) begin
              finished   <= 1'b0;
              flag_bits  <= in_byte;
              flags_left <= yaz0_pkg::FLAGS_PER_GROUP;
              phase      <= PH_ITEM;
            end else begin
              case (phase)
                PH_ITEM: begin
                  if ((flag_bits & yaz0_pkg::LIT_FLAG_MASK) != 8'd0) begin
                    flag_bits  <= flag_bits_next;
                    flags_left <= flags_left_next;
                    phase      <= phase_next;
                    if (!out_free) begin
                      lit_byte <= in_byte;
                      state    <= S_LIT;
                    end
                  end else begin
                    ref_high_byte <= in_byte;
                    phase         <= PH_LOW;
                  end
                end
                PH_LOW: begin
                  ref_low_byte <= in_byte;
                  if (ref_high_byte[7:4] == 4'd0) begin
                    phase <= PH_EXT;
                  end else begin
                    ref_dist <= {1'b0, ref_high_byte[3:0] & yaz0_pkg::DIST_HI_MASK, in_byte} +
                                yaz0_pkg::DIST_W'(1);
                    copy_left  <= {5'd0, ref_high_byte[7:4]} + yaz0_pkg::SHORT_LEN_BASE;
                    flag_bits  <= flag_bits_next;
                    flags_left <= flags_left_next;
                    phase      <= phase_next;
                    state      <= S_RD;
                  end
                end
                PH_EXT: begin
                  ref_dist <= {1'b0, ref_high_byte[3:0] & yaz0_pkg::DIST_HI_MASK,
                               ref_low_byte} + yaz0_pkg::DIST_W'(1);
                  copy_left  <= {1'b0, in_byte} + yaz0_pkg::EXT_LEN_BASE;
                  flag_bits  <= flag_bits_next;
                  flags_left <= flags_left_next;
                  phase      <= phase_next;
                  state      <= S_RD;
                end
                default: begin
                  phase <= PH_FLAG;
                end
              endcase
            end
          end
        end
        S_LIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          // source before the start of the stream reads as zero
          src_zero <= ({{(32-yaz0_pkg::DIST_W){1'b0}}, ref_dist} > logical_position);
          state    <= S_WR;
        end
        S_WR: begin
          if (out_free) begin
            copy_left <= copy_left - 9'd1;
            state     <= p_is_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/yaz0_checker.sv =====
// port-level checks for the yaz0 stream decompressor, bound to the top level
module yaz0_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [yaz0_pkg::OUT_W-1:0] out_bytes,
  input logic [3:0]                 byte_count,
  input logic                       last_of_run,
  input logic                       stream_done
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0) &&
                  (byte_count <= 4'(yaz0_pkg::GROUP_BYTES)))
    else $error("byte_count out of range");

  // a short group only ever closes a run
  a_partial_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count < 4'(yaz0_pkg::GROUP_BYTES)) |-> last_of_run)
    else $error("partial group not marked last");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> last_of_run)
    else $error("stream_done without last_of_run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_bytes) &&
                                  $stable(byte_count))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind yaz0_stream_decompressor_unit yaz0_checker u_yaz0_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_bytes   (out_bytes),
  .byte_count  (byte_count),
  .last_of_run (last_of_run),
  .stream_done (stream_done)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the yaz0 stream decompressor with its own decode predictor
module testbench;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 700;
  localparam int LONG_HOLD    = 500;
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic             sos;
    logic [7:0]       data;
  } payload_item_t;

  typedef struct packed {
    logic [yaz0_pkg::OUT_W-1:0] data;
    logic [3:0]       count;
    logic             last;
    logic             done;
  } byte_group_t;

  typedef enum logic [1:0] {WANT_FLAGS, WANT_ITEM, WANT_LOW, WANT_EXT} parse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [yaz0_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [yaz0_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_of_stream = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [yaz0_pkg::OUT_W-1:0] out_bytes;
  logic [3:0] byte_count;
  logic last_of_run;
  logic stream_done;

  yaz0_stream_decompressor_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_of_stream(start_of_stream),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bytes(out_bytes),
    .byte_count(byte_count),
    .last_of_run(last_of_run),
    .stream_done(stream_done)
  );

  always #4 clk = ~clk;

  payload_item_t payload_q[$];
  byte_group_t expected_groups[$];
  int items_queued = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // decoder copy kept by the testbench
  logic [7:0] window_mem [yaz0_pkg::WINDOW_DEPTH];
  parse_t phase_s;
  logic [7:0] flags_s;
  logic [3:0] flags_left_s;
  logic [7:0] hi_s;
  logic [7:0] lo_s;
  logic [31:0] pos_s;
  logic [31:0] emitted_s;
  logic finished_s;
  logic [31:0] size_cfg;
  logic [31:0] skip_cfg;
  logic [31:0] limit_cfg;
  logic [yaz0_pkg::OUT_W-1:0] grp_word;
  int grp_fill;
  int run_results;

  function void reset_model();
    for (int i = 0; i < yaz0_pkg::WINDOW_DEPTH; i++) window_mem[i] = 8'h00;
    phase_s = WANT_FLAGS;
    flags_s = '0;
    flags_left_s = '0;
    hi_s = '0;
    lo_s = '0;
    pos_s = '0;
    emitted_s = '0;
    finished_s = 1'b0;
    size_cfg = '0;
    skip_cfg = '0;
    limit_cfg = yaz0_pkg::EMIT_LIMIT_RESET;
  endfunction

  function void seal_group();
    byte_group_t g;
    if (grp_fill == 0) return;
    g.data = grp_word;
    g.count = 4'(grp_fill);
    g.last = 1'b0;
    g.done = 1'b0;
    expected_groups = {expected_groups, g};
    run_results++;
    grp_word = '0;
    grp_fill = 0;
  endfunction

  function void put_byte(input logic [7:0] b);
    if (finished_s) return;
    window_mem[pos_s[yaz0_pkg::HIST_AW-1:0]] = b;
    if (pos_s >= skip_cfg && emitted_s < limit_cfg) begin
      grp_word[8*grp_fill +: 8] = b;
      grp_fill++;
      emitted_s++;
      if (grp_fill == yaz0_pkg::GROUP_BYTES) seal_group();
    end
    pos_s++;
    if (pos_s >= size_cfg || emitted_s >= limit_cfg) finished_s = 1'b1;
  endfunction

  function void copy_match(input logic [31:0] ref_dist, input int len);
    logic [7:0] b;
    logic [31:0] src_pos;
    for (int i = 0; i < len && !finished_s; i++) begin
      b = 8'h00;
      // source before the stream start reads zero
      if (ref_dist <= pos_s) begin
        src_pos = pos_s - ref_dist;
        b = window_mem[src_pos[yaz0_pkg::HIST_AW-1:0]];
      end
      put_byte(b);
    end
  endfunction

  function void next_flag();
    flags_s = flags_s << 1;
    flags_left_s = flags_left_s - 4'd1;
    phase_s = (flags_left_s == 0) ? WANT_FLAGS : WANT_ITEM;
  endfunction

  function void decode_byte(input logic sos, input logic [7:0] b);
    logic [31:0] ref_dist;
    if (sos) begin
      phase_s = WANT_FLAGS;
      flags_s = '0;
      flags_left_s = '0;
      hi_s = '0;
      lo_s = '0;
      pos_s = '0;
      emitted_s = '0;
      finished_s = 1'b0;
    end
    if (!finished_s && (pos_s >= size_cfg || emitted_s >= limit_cfg)) finished_s = 1'b1;
    if (finished_s) return;
    run_results = 0;
    grp_word = '0;
    grp_fill = 0;
    case (phase_s)
      WANT_FLAGS: begin
        flags_s = b;
        flags_left_s = yaz0_pkg::FLAGS_PER_GROUP;
        phase_s = WANT_ITEM;
      end
      WANT_ITEM: begin
        if ((flags_s & yaz0_pkg::LIT_FLAG_MASK) != 0) begin
          put_byte(b);
          next_flag();
        end else begin
          hi_s = b;
          phase_s = WANT_LOW;
        end
      end
      WANT_LOW: begin
        lo_s = b;
        if (hi_s[7:4] == 4'h0) begin
          phase_s = WANT_EXT;
        end else begin
          ref_dist = 32'({hi_s[3:0] & yaz0_pkg::DIST_HI_MASK, lo_s}) + 32'd1;
          copy_match(ref_dist, int'(hi_s[7:4]) + int'(yaz0_pkg::SHORT_LEN_BASE));
          next_flag();
        end
      end
      default: begin
        ref_dist = 32'({hi_s[3:0] & yaz0_pkg::DIST_HI_MASK, lo_s}) + 32'd1;
        copy_match(ref_dist, int'(b) + int'(yaz0_pkg::EXT_LEN_BASE));
        next_flag();
      end
    endcase
    seal_group();
    if (run_results > 0) begin
      expected_groups[expected_groups.size() - 1].last = 1'b1;
      expected_groups[expected_groups.size() - 1].done = finished_s;
    end
  endfunction

  function void report(input string what, input logic [yaz0_pkg::OUT_W-1:0] want, got);
    fail_count++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  // driver: bursts of items with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    payload_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (payload_q.size() > 0) begin
        it = payload_q.pop_front();
        in_valid <= 1'b1;
        start_of_stream <= it.sos;
        in_byte <= it.data;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall modes in stretches, plus long hold-offs to back up the input
  int taken_count = 0;
  int hold_left = 0;
  int next_hold_at = 60;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken_count++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (taken_count >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at = next_hold_at + 250;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // monitor: predict on each accepted item, then check each accepted result
  always @(posedge clk) begin
    byte_group_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_byte(start_of_stream, in_byte);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_groups.size() == 0) begin
          report("unexpected result out_bytes", '0, out_bytes);
        end else begin
          want = expected_groups.pop_front();
          if (out_bytes !== want.data) report("out_bytes", want.data, out_bytes);
          if (byte_count !== want.count) report("byte_count", 64'(want.count), 64'(byte_count));
          if (last_of_run !== want.last) report("last_of_run", 64'(want.last), 64'(last_of_run));
          if (stream_done !== want.done) report("stream_done", 64'(want.done), 64'(stream_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function void queue_byte(input logic sos, input logic [7:0] b);
    payload_item_t it;
    it.sos = sos;
    it.data = b;
    payload_q = {payload_q, it};
    items_queued++;
  endfunction

  // well-formed flag groups with random literals and references
  function int queue_stream(input int n, input logic fresh);
    int sent;
    logic [7:0] flags;
    logic [11:0] dist_field;
    logic [3:0] nib;
    sent = 0;
    while (sent < n) begin
      flags = 8'($urandom);
      queue_byte(fresh, flags);
      fresh = 1'b0;
      sent++;
      for (int k = 0; k < 8 && sent < n; k++) begin
        if (flags[7-k]) begin
          queue_byte(1'b0, 8'($urandom));
          sent++;
        end else begin
          dist_field = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(0, 40));
          nib = ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
          queue_byte(1'b0, {nib, dist_field[11:8]});
          queue_byte(1'b0, dist_field[7:0]);
          sent += 2;
          if (nib == 4'h0) begin
            queue_byte(1'b0, ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 24)));
            sent++;
          end
        end
      end
    end
    return sent;
  endfunction

  task write_reg(input logic [yaz0_pkg::CFG_IDX_W-1:0] idx,
                 input logic [yaz0_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      yaz0_pkg::REG_EXPANDED_SIZE: size_cfg = val;
      yaz0_pkg::REG_SKIP_COUNT: skip_cfg = val;
      yaz0_pkg::REG_EMIT_LIMIT: limit_cfg = val;
      default: ;
    endcase
  endtask

  task configure(input logic [31:0] size_v, skip_v, limit_v);
    write_reg(yaz0_pkg::REG_EXPANDED_SIZE, size_v);
    write_reg(yaz0_pkg::REG_SKIP_COUNT, skip_v);
    write_reg(yaz0_pkg::REG_EMIT_LIMIT, limit_v);
    cfg_we <= 1'b0;
  endtask

  // wait for every item and result, then for a copy that emits nothing
  task settle();
    while (items_accepted != items_queued || expected_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_items;
    int n;
    logic [31:0] size_v;
    logic [31:0] skip_v;
    logic [31:0] limit_v;
    logic keep;
    reset_model();
    random_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // literals, a reference before the start, longest and overlapping copies
    configure(32'd1000, 32'd0, 32'hFFFF_FFFF);
    queue_byte(1'b1, 8'hB0);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h1F);
    queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'h5A);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'hF0);
    queue_byte(1'b0, 8'h01);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h02);
    queue_byte(1'b0, 8'h00);
    settle();

    // register change in the middle of a stream, copy cut at the size
    configure(32'd317, 32'd0, 32'hFFFF_FFFF);
    queue_byte(1'b0, 8'h30);
    queue_byte(1'b0, 8'h01);
    settle();

    // new stream over old history: zeros, skipped head, cut by the limit, then ignored
    configure(32'd20, 32'd3, 32'd5);
    queue_byte(1'b1, 8'h40);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h10);
    queue_byte(1'b0, 8'hC3);
    queue_byte(1'b0, 8'h7E);
    settle();

    // zero size
    configure(32'd0, 32'd0, 32'hFFFF_FFFF);
    queue_byte(1'b1, 8'hFF);
    settle();

    // skip past the size
    configure(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_byte(1'b1, 8'hFF);
    queue_byte(1'b0, 8'h11);
    queue_byte(1'b0, 8'h22);
    queue_byte(1'b0, 8'h33);
    queue_byte(1'b0, 8'h44);
    settle();

    // zero limit
    configure(32'd100, 32'd0, 32'd0);
    queue_byte(1'b1, 8'h80);
    settle();

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: size_v = 32'hFFFF_FFFF;
        1: size_v = $urandom_range(1, 30);
        default: size_v = $urandom_range(50, 3000);
      endcase
      case ($urandom_range(0, 9))
        6, 7: skip_v = $urandom_range(1, 40);
        8: skip_v = $urandom_range(100, 2000);
        9: skip_v = $urandom;
        default: skip_v = 32'd0;
      endcase
      limit_v = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(1, 400)) : 32'hFFFF_FFFF;
      configure(size_v, skip_v, limit_v);
      keep = (random_items > 0) && ($urandom_range(0, 3) == 0);
      n = queue_stream($urandom_range(12, 48), !keep);
      random_items += n;
      // noise: random bytes, now and then restarting the stream
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_byte($urandom_range(0, 7) == 0, 8'($urandom));
        random_items += n;
      end
      settle();
    end

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
